// ===== rtl/scsa_pkg.sv =====
// Package for the size-class slot allocator: field widths, class and status
// codes, the class thresholds and a helper that builds slot masks.
// No dependencies.
package scsa_pkg;

  localparam int unsigned MODE_W    = 1;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CLASS_W   = 2;
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned CNT_W     = 7;

  localparam int unsigned SMALL_SLOTS_DEF  = 32;
  localparam int unsigned MEDIUM_SLOTS_DEF = 32;
  localparam int unsigned LARGE_SLOTS_DEF  = 32;

  localparam logic [SIZE_W-1:0] SMALL_LIMIT  = 16'd8;
  localparam logic [SIZE_W-1:0] MEDIUM_LIMIT = 16'd16;
  localparam logic [SIZE_W-1:0] LARGE_LIMIT  = 16'd32;

  localparam logic [MODE_W-1:0] MODE_ACQUIRE = 1'b0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_SMALL  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LARGE  = 2'd2,
    CLS_NONE   = 2'd3
  } size_class_t;

  // Mask with the low n bits set, n clamped to the bitmap width.
  function automatic logic [MAX_SLOTS-1:0] slot_mask(int unsigned n);
    logic [MAX_SLOTS-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/scsa_if.sv =====
// Valid/ready channel interfaces for the size-class slot allocator:
// one for requests and one for results.
// Depends on scsa_pkg.
interface scsa_req_if;
  logic                          valid;
  logic                          ready;
  logic [scsa_pkg::MODE_W-1:0]   mode;
  logic [scsa_pkg::SIZE_W-1:0]   req_size;
  logic [scsa_pkg::SLOT_W-1:0]   release_slot;

  modport source (output valid, mode, req_size, release_slot, input ready);
  modport sink   (input valid, mode, req_size, release_slot, output ready);
endinterface

interface scsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [scsa_pkg::STATUS_W-1:0]  status;
  logic [scsa_pkg::CLASS_W-1:0]   size_class;
  logic [scsa_pkg::SLOT_W-1:0]    slot;

  modport source (output valid, status, size_class, slot, input ready);
  modport sink   (input valid, status, size_class, slot, output ready);
endinterface

// ===== rtl/size_class_slot_allocator_unit.sv =====
// Size-class slot allocator: three in-use bitmaps served one request a cycle while out_rsp is not stalled.
// Depends on scsa_pkg and the channel interfaces in scsa_if.sv.
//
// Usage: requests arrive on in_req (mode, req_size, release_slot) and each
// gives exactly one result beat on out_rsp (status, size_class, slot).
// A count of 8 or less maps to the small class, 16 or less to medium,
// 32 or less to large; anything larger is refused without touching state.
// An acquire grants the lowest free slot of its class; a release frees the
// named slot, or is ignored when the slot lies outside the class.
// Flow: a request accepted into the input register moves into the result
// register when that register is empty or its beat is taken, and its result
// beat is then offered on out_rsp. Throughput: one request per cycle while
// out_rsp is not stalled; the bitmap update and lowest-free-slot encode sit
// between the two registers, and a bitmap changes at the same edge its result
// is registered, so the next request always sees it.
// Reset (rst_n low, synchronous) frees every slot and empties both stages.
// When the receiver holds out_rsp.ready low, the result holds, the request
// in the input register waits, and in_req.ready stays high only while the
// input register is empty.
module size_class_slot_allocator_unit #(
  parameter int unsigned SMALL_SLOTS  = scsa_pkg::SMALL_SLOTS_DEF,
  parameter int unsigned MEDIUM_SLOTS = scsa_pkg::MEDIUM_SLOTS_DEF,
  parameter int unsigned LARGE_SLOTS  = scsa_pkg::LARGE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  scsa_req_if.sink          in_req,
  scsa_rsp_if.source        out_rsp
);

  localparam int unsigned MW = scsa_pkg::MAX_SLOTS;
  localparam logic [MW-1:0] SMALL_MASK  = scsa_pkg::slot_mask(SMALL_SLOTS);
  localparam logic [MW-1:0] MEDIUM_MASK = scsa_pkg::slot_mask(MEDIUM_SLOTS);
  localparam logic [MW-1:0] LARGE_MASK  = scsa_pkg::slot_mask(LARGE_SLOTS);
  localparam logic [scsa_pkg::CNT_W-1:0] SMALL_N  = scsa_pkg::CNT_W'(SMALL_SLOTS);
  localparam logic [scsa_pkg::CNT_W-1:0] MEDIUM_N = scsa_pkg::CNT_W'(MEDIUM_SLOTS);
  localparam logic [scsa_pkg::CNT_W-1:0] LARGE_N  = scsa_pkg::CNT_W'(LARGE_SLOTS);

  // Input register.
  logic                            req_vld_r;
  logic [scsa_pkg::MODE_W-1:0]     mode_r;
  logic [scsa_pkg::SIZE_W-1:0]     req_size_r;
  logic [scsa_pkg::SLOT_W-1:0]     rel_slot_r;

  // Result register.
  logic                            rsp_vld_r;
  scsa_pkg::status_t               status_r, status_nxt;
  scsa_pkg::size_class_t           cls_r, cls_nxt;
  logic [scsa_pkg::SLOT_W-1:0]     slot_r, slot_nxt;

  // In-use bitmaps.
  logic [SMALL_SLOTS-1:0]          small_map_r, small_map_nxt;
  logic [MEDIUM_SLOTS-1:0]         medium_map_r, medium_map_nxt;
  logic [LARGE_SLOTS-1:0]          large_map_r, large_map_nxt;

  logic                            advance;
  logic [MW-1:0]                   small_ext, medium_ext, large_ext;
  logic [MW-1:0]                   map_sel, mask_sel, free_bits, low_bit, set_bits, clr_bits;
  logic [scsa_pkg::CNT_W-1:0]      n_sel;
  logic [scsa_pkg::SLOT_W-1:0]     free_idx;
  logic                            do_set, do_clr;

  assign advance      = !rsp_vld_r || out_rsp.ready;
  assign in_req.ready = !req_vld_r || advance;

  assign small_ext  = MW'(small_map_r);
  assign medium_ext = MW'(medium_map_r);
  assign large_ext  = MW'(large_map_r);

  always_comb begin
    cls_nxt = scsa_pkg::CLS_NONE;
    if (req_size_r <= scsa_pkg::SMALL_LIMIT) begin
      cls_nxt = scsa_pkg::CLS_SMALL;
    end else if (req_size_r <= scsa_pkg::MEDIUM_LIMIT) begin
      cls_nxt = scsa_pkg::CLS_MEDIUM;
    end else if (req_size_r <= scsa_pkg::LARGE_LIMIT) begin
      cls_nxt = scsa_pkg::CLS_LARGE;
    end

    unique case (cls_nxt)
      scsa_pkg::CLS_SMALL: begin
        map_sel = small_ext;  mask_sel = SMALL_MASK;  n_sel = SMALL_N;
      end
      scsa_pkg::CLS_MEDIUM: begin
        map_sel = medium_ext; mask_sel = MEDIUM_MASK; n_sel = MEDIUM_N;
      end
      scsa_pkg::CLS_LARGE: begin
        map_sel = large_ext;  mask_sel = LARGE_MASK;  n_sel = LARGE_N;
      end
      default: begin
        map_sel = '0;         mask_sel = '0;          n_sel = '0;
      end
    endcase

    // Isolate the lowest free bit, then encode its position.
    free_bits = ~map_sel & mask_sel;
    low_bit   = free_bits & (~free_bits + MW'(1));
    free_idx  = '0;
    for (int unsigned i = 0; i < MW; i++) begin
      if (low_bit[i]) free_idx = free_idx | scsa_pkg::SLOT_W'(i);
    end

    clr_bits   = MW'(1) << rel_slot_r;
    set_bits   = low_bit;
    do_set     = 1'b0;
    do_clr     = 1'b0;
    slot_nxt   = '0;
    status_nxt = scsa_pkg::ST_TOO_LARGE;

    if (cls_nxt != scsa_pkg::CLS_NONE) begin
      if (mode_r == scsa_pkg::MODE_ACQUIRE) begin
        if (free_bits == '0) begin
          status_nxt = scsa_pkg::ST_EXHAUSTED;
        end else begin
          status_nxt = scsa_pkg::ST_GRANTED;
          slot_nxt   = free_idx;
          do_set     = 1'b1;
        end
      end else if ({1'b0, rel_slot_r} < n_sel) begin
        status_nxt = scsa_pkg::ST_RELEASED;
        slot_nxt   = rel_slot_r;
        do_clr     = 1'b1;
      end else begin
        status_nxt = scsa_pkg::ST_IGNORED;
      end
    end

    small_map_nxt  = small_map_r;
    medium_map_nxt = medium_map_r;
    large_map_nxt  = large_map_r;
    if (req_vld_r && advance) begin
      unique case (cls_nxt)
        scsa_pkg::CLS_SMALL: begin
          if (do_set) small_map_nxt = small_map_r | set_bits[SMALL_SLOTS-1:0];
          if (do_clr) small_map_nxt = small_map_r & ~clr_bits[SMALL_SLOTS-1:0];
        end
        scsa_pkg::CLS_MEDIUM: begin
          if (do_set) medium_map_nxt = medium_map_r | set_bits[MEDIUM_SLOTS-1:0];
          if (do_clr) medium_map_nxt = medium_map_r & ~clr_bits[MEDIUM_SLOTS-1:0];
        end
        scsa_pkg::CLS_LARGE: begin
          if (do_set) large_map_nxt = large_map_r | set_bits[LARGE_SLOTS-1:0];
          if (do_clr) large_map_nxt = large_map_r & ~clr_bits[LARGE_SLOTS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r    <= 1'b0;
      rsp_vld_r    <= 1'b0;
      small_map_r  <= '0;
      medium_map_r <= '0;
      large_map_r  <= '0;
    end else begin
      small_map_r  <= small_map_nxt;
      medium_map_r <= medium_map_nxt;
      large_map_r  <= large_map_nxt;
      if (in_req.ready) begin
        req_vld_r <= in_req.valid;
      end
      if (advance) begin
        rsp_vld_r <= req_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      mode_r     <= in_req.mode;
      req_size_r <= in_req.req_size;
      rel_slot_r <= in_req.release_slot;
    end
    if (req_vld_r && advance) begin
      status_r <= status_nxt;
      cls_r    <= cls_nxt;
      slot_r   <= slot_nxt;
    end
  end

  assign out_rsp.valid      = rsp_vld_r;
  assign out_rsp.status     = status_r;
  assign out_rsp.size_class = cls_r;
  assign out_rsp.slot       = slot_r;

  // A grant on display is still marked in use in its class bitmap.
  a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld_r && status_r == scsa_pkg::ST_GRANTED |->
      (cls_r == scsa_pkg::CLS_SMALL  && small_ext[slot_r])  ||
      (cls_r == scsa_pkg::CLS_MEDIUM && medium_ext[slot_r]) ||
      (cls_r == scsa_pkg::CLS_LARGE  && large_ext[slot_r]))
    else $error("granted slot not marked in use");

  // The class is none exactly for a too-large refusal.
  a_none_iff_large: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld_r |->
      ((status_r == scsa_pkg::ST_TOO_LARGE) == (cls_r == scsa_pkg::CLS_NONE)))
    else $error("class none and too-large status disagree");

  // Bitmaps change only when a request moves into the result register.
  a_map_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_vld_r && advance) |=>
      $stable(small_map_r) && $stable(medium_map_r) && $stable(large_map_r))
    else $error("bitmap changed without a request");

  // Reset empties both stages.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !rsp_vld_r && !req_vld_r)
    else $error("stages not empty after reset");

endmodule

// ===== dv/tb_size_class_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Testbench for size_class_slot_allocator_unit: directed and random acquire and release
// beats, each result checked against an in-bench model of the three in-use bitmaps.
// Depends on scsa_pkg, the channel interfaces in scsa_if.sv and the RTL top level.
module tb_size_class_slot_allocator_unit;

  localparam int unsigned NUM_REQUESTS   = 900;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_CLASSES    = 3;

  typedef struct {
    logic [scsa_pkg::MODE_W-1:0] mode;
    logic [scsa_pkg::SIZE_W-1:0] req_size;
    logic [scsa_pkg::SLOT_W-1:0] release_slot;
    bit                          drain_first;
  } alloc_req_t;

  typedef struct {
    scsa_pkg::status_t           status;
    scsa_pkg::size_class_t       size_class;
    logic [scsa_pkg::SLOT_W-1:0] slot;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  scsa_req_if in_req ();
  scsa_rsp_if out_rsp ();

  size_class_slot_allocator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  alloc_req_t  pending_requests[$];
  alloc_rsp_t  predicted_outcomes[$];
  logic [scsa_pkg::MAX_SLOTS-1:0] slots_taken [NUM_CLASSES];
  int unsigned slots_per_class [NUM_CLASSES] = '{scsa_pkg::SMALL_SLOTS_DEF,
                                                 scsa_pkg::MEDIUM_SLOTS_DEF,
                                                 scsa_pkg::LARGE_SLOTS_DEF};
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned errors = 0;
  int unsigned quiet_cycles;
  int unsigned src_gap;
  int unsigned sink_stall;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b0;

  // Works out the result of one request and updates the bitmaps the way the block should.
  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t  o;
    int unsigned idx;
    o.slot = '0;
    if (r.req_size > scsa_pkg::LARGE_LIMIT) begin
      o.status     = scsa_pkg::ST_TOO_LARGE;
      o.size_class = scsa_pkg::CLS_NONE;
      return o;
    end
    if (r.req_size <= scsa_pkg::SMALL_LIMIT) begin
      o.size_class = scsa_pkg::CLS_SMALL;
    end else if (r.req_size <= scsa_pkg::MEDIUM_LIMIT) begin
      o.size_class = scsa_pkg::CLS_MEDIUM;
    end else begin
      o.size_class = scsa_pkg::CLS_LARGE;
    end
    idx = o.size_class;
    if (r.mode == scsa_pkg::MODE_ACQUIRE) begin
      o.status = scsa_pkg::ST_EXHAUSTED;
      // Scanning downward leaves the lowest free slot as the grant.
      for (int i = int'(slots_per_class[idx]) - 1; i >= 0; i--) begin
        if (!slots_taken[idx][i]) begin
          o.status = scsa_pkg::ST_GRANTED;
          o.slot   = scsa_pkg::SLOT_W'(i);
        end
      end
      if (o.status == scsa_pkg::ST_GRANTED) slots_taken[idx][o.slot] = 1'b1;
    end else if (r.release_slot >= slots_per_class[idx]) begin
      o.status = scsa_pkg::ST_IGNORED;
    end else begin
      o.status = scsa_pkg::ST_RELEASED;
      o.slot   = r.release_slot;
      slots_taken[idx][r.release_slot] = 1'b0;
    end
    return o;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [scsa_pkg::SIZE_W-1:0] size_for(scsa_pkg::size_class_t c);
    case (c)
      scsa_pkg::CLS_SMALL:
        return scsa_pkg::SIZE_W'($urandom_range(0, scsa_pkg::SMALL_LIMIT));
      scsa_pkg::CLS_MEDIUM:
        return scsa_pkg::SIZE_W'($urandom_range(scsa_pkg::SMALL_LIMIT + 1,
                                                scsa_pkg::MEDIUM_LIMIT));
      scsa_pkg::CLS_LARGE:
        return scsa_pkg::SIZE_W'($urandom_range(scsa_pkg::MEDIUM_LIMIT + 1,
                                                scsa_pkg::LARGE_LIMIT));
      default: begin
        if ($urandom_range(0, 1) == 0)
          return scsa_pkg::SIZE_W'($urandom_range(scsa_pkg::LARGE_LIMIT + 1, 40));
        return scsa_pkg::SIZE_W'($urandom_range(scsa_pkg::LARGE_LIMIT + 1, 65535));
      end
    endcase
  endfunction

  task automatic add_req(input logic [scsa_pkg::MODE_W-1:0] mode,
                         input int unsigned req_size,
                         input int unsigned release_slot, input bit drain_first);
    alloc_req_t r;
    r.mode         = mode;
    r.req_size     = scsa_pkg::SIZE_W'(req_size);
    r.release_slot = scsa_pkg::SLOT_W'(release_slot);
    r.drain_first  = drain_first;
    pending_requests.push_back(r);
  endtask

  // Request driver: holds a beat until it is taken, then may idle for a random gap.
  always @(posedge clk) begin : drive_requests
    bit          took;
    bit          show;
    int unsigned in_count;
    int unsigned out_count;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      beats_in     <= 0;
      src_gap      = 0;
      for (int k = 0; k < NUM_CLASSES; k++) slots_taken[k] = '0;
    end else begin
      took = in_req.valid && in_req.ready;
      if (took) begin
        predicted_outcomes.push_back(predict_alloc(pending_requests.pop_front()));
        if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
        src_gap = (src_calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
      end
      in_count  = beats_in + took;
      out_count = beats_out + (out_rsp.valid && out_rsp.ready);
      show      = in_req.valid && !took;
      if (!show) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_requests.size() > 0 &&
                     (!pending_requests[0].drain_first || in_count == out_count)) begin
          show                = 1'b1;
          in_req.mode         <= pending_requests[0].mode;
          in_req.req_size     <= pending_requests[0].req_size;
          in_req.release_slot <= pending_requests[0].release_slot;
        end
      end
      in_req.valid <= show;
      beats_in     <= in_count;
    end
  end

  // Result monitor: random back-pressure and a field-by-field check of each result beat.
  always @(posedge clk) begin : check_results
    alloc_rsp_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      beats_out     <= 0;
      sink_stall    = 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        if (beats_out >= beats_in) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = predicted_outcomes.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp.status);
            errors++;
          end
          if (out_rsp.size_class !== want.size_class) begin
            $error("size_class: expected %0d, got %0d", want.size_class, out_rsp.size_class);
            errors++;
          end
          if (out_rsp.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_rsp.slot);
            errors++;
          end
        end
        beats_out <= beats_out + 1;
      end
      if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
      if (sink_stall > 0) begin
        sink_stall--;
        out_rsp.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
        sink_stall = idle_len() - 1;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_size_class_slot_allocator_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    scsa_pkg::size_class_t c;
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.mode         = scsa_pkg::MODE_ACQUIRE;
    in_req.req_size     = '0;
    in_req.release_slot = '0;
    out_rsp.ready       = 1'b0;

    // Class boundaries, oversized counts in both modes, and the release corner cases.
    add_req(scsa_pkg::MODE_ACQUIRE, 0, 63, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 8, 0, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 9, 21, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 16, 0, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 17, 42, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 32, 0, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 33, 0, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 65535, 63, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 65535, 0, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 33, 63, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 1, 0, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 4, 0, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 2, 5, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 8, 31, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 0, 32, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 12, 63, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 32, 1, 1'b0);
    add_req(scsa_pkg::MODE_ACQUIRE, 20, 42, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 9, 0, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 16, 1, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 17, 0, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 31, 1, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 3, 0, 1'b0);
    add_req(scsa_pkg::MODE_RELEASE, 7, 1, 1'b0);

    // Random episodes: fill a class past exhaustion, drain one, or mix everything.
    while (pending_requests.size() < NUM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      c    = scsa_pkg::size_class_t'($urandom_range(0, 2));
      if (kind < 30) begin
        n = $urandom_range(33, 38);
        for (int i = 0; i < n; i++) begin
          add_req(scsa_pkg::MODE_ACQUIRE, size_for(c), $urandom_range(0, 63),
                  i == 0 && $urandom_range(0, 7) == 0);
        end
      end else if (kind < 55) begin
        n = $urandom_range(10, 40);
        for (int i = 0; i < n; i++) begin
          add_req(scsa_pkg::MODE_RELEASE, size_for(c),
                  ($urandom_range(0, 99) < 85) ? $urandom_range(0, slots_per_class[c] - 1)
                                               : $urandom_range(0, 63),
                  i == 0 && $urandom_range(0, 7) == 0);
        end
      end else begin
        n = $urandom_range(5, 20);
        for (int i = 0; i < n; i++) begin
          c = ($urandom_range(0, 9) == 0) ? scsa_pkg::CLS_NONE
                                          : scsa_pkg::size_class_t'($urandom_range(0, 2));
          add_req(scsa_pkg::MODE_W'($urandom_range(0, 1)), size_for(c),
                  $urandom_range(0, 63), i == 0 && $urandom_range(0, 7) == 0);
        end
      end
    end
    // The first random beat always waits for the directed part to drain completely.
    pending_requests[24].drain_first = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // A request leaves the pending queue and enters the expected queue in one step,
    // so both queues empty means every result has been checked.
    while (pending_requests.size() > 0 || predicted_outcomes.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (predicted_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", predicted_outcomes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_size_class_slot_allocator_unit passed");
    end else begin
      $display("tb_size_class_slot_allocator_unit failed");
    end
    $finish;
  end

endmodule
